// ===== hw/rtl/text_sprite_command_port_macros.svh =====
// Assertion macros for the text and sprite command port.
// Depends on nothing; included by the top level, which asserts.
`ifndef TEXT_SPRITE_COMMAND_PORT_MACROS_SVH
`define TEXT_SPRITE_COMMAND_PORT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion that is switched off while reset is applied.
`define TSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSP_ASSERT(label, clk, rstn, prop, msg)
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants of the text and sprite command port.
// No dependencies; used by every module of the block.
package tsp_pkg;

    // Port selector of one bus access.
    localparam logic [1:0] PORT_CMD    = 2'd0;
    localparam logic [1:0] PORT_PARAM  = 2'd1;
    localparam logic [1:0] PORT_STATUS = 2'd2;
    localparam logic [1:0] PORT_UNUSED = 2'd3;

    // Command bytes.
    localparam logic [7:0] OP_TIMING_SET    = 8'h10;
    localparam logic [7:0] OP_TEXT_ENABLE   = 8'h12;
    localparam logic [7:0] OP_TEXT_FORMAT   = 8'h14;
    localparam logic [7:0] OP_CURSOR_SET    = 8'h15;
    localparam logic [7:0] OP_SPRITE_ENABLE = 8'h82;
    localparam logic [7:0] OP_SPRITE_LOAD   = 8'h84;

    // Parameter byte counts.
    localparam logic [3:0] SYNC_BYTES   = 4'd14;
    localparam logic [3:0] DSPON_BYTES  = 4'd3;
    localparam logic [3:0] DSPDEF_BYTES = 4'd6;
    localparam logic [3:0] CURDEF_BYTES = 4'd1;
    localparam logic [3:0] SPRON_BYTES  = 4'd3;

    // Parameter slots that feed display registers.
    localparam logic [3:0] SLOT_0      = 4'd0;
    localparam logic [3:0] SLOT_1      = 4'd1;
    localparam logic [3:0] SLOT_3      = 4'd3;
    localparam logic [3:0] SLOT_LINES  = 4'd10;
    localparam logic [3:0] SLOT_LINES8 = 4'd11;

    // Parameter port modes.
    localparam logic [1:0] MODE_NOP        = 2'd0;
    localparam logic [1:0] MODE_COLLECT    = 2'd1;
    localparam logic [1:0] MODE_SPR_BEGIN  = 2'd2;
    localparam logic [1:0] MODE_SPR_STREAM = 2'd3;

    // Pending command codes.
    localparam logic [2:0] DO_SYNC   = 3'd0;
    localparam logic [2:0] DO_DSPON  = 3'd1;
    localparam logic [2:0] DO_DSPDEF = 3'd2;
    localparam logic [2:0] DO_CURDEF = 3'd3;
    localparam logic [2:0] DO_SPRON  = 3'd4;

    // Text memory operations.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_WRITE = 2'd1;
    localparam logic [1:0] MEM_SET   = 2'd2;
    localparam logic [1:0] MEM_CLEAR = 2'd3;

    localparam logic [7:0] BUSY_FLAG     = 8'h04;
    localparam logic [7:0] STATUS_VBLANK = 8'h40;
    localparam logic [7:0] UNUSED_READ   = 8'hff;
    localparam logic [7:0] CURSOR_MASK   = 8'h02;

    // Decoded command byte.
    typedef struct packed {
        logic       collect;
        logic       spr_begin;
        logic [3:0] bytes;
        logic [2:0] pending;
    } cmd_dec_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  mem_op;
        logic [15:0] mem_addr;
        logic [7:0]  mem_data;
        logic        display_on;
        logic        sprites_on;
        logic [15:0] text_table_base;
        logic [15:0] sprite_table_base;
        logic [15:0] attr_offset;
        logic [8:0]  line_height;
        logic [8:0]  screen_lines;
        logic        lines_changed;
    } result_t;

endpackage

// ===== hw/rtl/tsp_cmd_decode.sv =====
// Command byte decoder of the text and sprite command port.
// Depends on tsp_pkg.
module tsp_cmd_decode (
    input  logic [7:0]        cmd_byte,
    output tsp_pkg::cmd_dec_t dec
);

    always_comb begin
        dec = '0;
        unique case (cmd_byte)
            tsp_pkg::OP_TIMING_SET: begin
                dec.collect = 1'b1;
                dec.bytes   = tsp_pkg::SYNC_BYTES;
                dec.pending = tsp_pkg::DO_SYNC;
            end
            tsp_pkg::OP_TEXT_ENABLE: begin
                dec.collect = 1'b1;
                dec.bytes   = tsp_pkg::DSPON_BYTES;
                dec.pending = tsp_pkg::DO_DSPON;
            end
            tsp_pkg::OP_TEXT_FORMAT: begin
                dec.collect = 1'b1;
                dec.bytes   = tsp_pkg::DSPDEF_BYTES;
                dec.pending = tsp_pkg::DO_DSPDEF;
            end
            tsp_pkg::OP_CURSOR_SET: begin
                dec.collect = 1'b1;
                dec.bytes   = tsp_pkg::CURDEF_BYTES;
                dec.pending = tsp_pkg::DO_CURDEF;
            end
            tsp_pkg::OP_SPRITE_ENABLE: begin
                dec.collect = 1'b1;
                dec.bytes   = tsp_pkg::SPRON_BYTES;
                dec.pending = tsp_pkg::DO_SPRON;
            end
            tsp_pkg::OP_SPRITE_LOAD: begin
                dec.spr_begin = 1'b1;
            end
            default: begin
                dec = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tsp_core.sv =====
// Command state and display registers of the text and sprite command port.
// Depends on tsp_pkg and tsp_cmd_decode.
module tsp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [1:0]        command,
    input  logic [7:0]        data_byte,
    input  logic              vblank,
    output tsp_pkg::result_t  result
);

    tsp_pkg::cmd_dec_t dec;

    logic        busy_reg, busy_next;
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  pending_reg, pending_next;
    logic [3:0]  bytes_reg, bytes_next;
    logic [3:0]  slot_reg, slot_next;
    logic [15:0] offset_reg, offset_next;
    logic [7:0]  p0_reg, p0_next;
    logic [7:0]  p1_reg, p1_next;
    logic [7:0]  p3_reg, p3_next;
    logic [7:0]  p10_reg, p10_next;
    logic [7:0]  p11_reg, p11_next;
    logic [7:0]  text_reg, text_next;
    logic [7:0]  spr_reg, spr_next;
    logic [15:0] attr_reg, attr_next;
    logic [8:0]  lh_reg, lh_next;
    logic [8:0]  lines_reg, lines_next;
    logic        dspon_reg, dspon_next;
    logic        spron_reg, spron_next;
    logic [8:0]  lines_new;

    tsp_cmd_decode u_decode (
        .cmd_byte (data_byte),
        .dec      (dec)
    );

    always_comb begin
        busy_next    = busy_reg;
        mode_next    = mode_reg;
        pending_next = pending_reg;
        bytes_next   = bytes_reg;
        slot_next    = slot_reg;
        offset_next  = offset_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        p3_next      = p3_reg;
        p10_next     = p10_reg;
        p11_next     = p11_reg;
        text_next    = text_reg;
        spr_next     = spr_reg;
        attr_next    = attr_reg;
        lh_next      = lh_reg;
        lines_next   = lines_reg;
        dspon_next   = dspon_reg;
        spron_next   = spron_reg;
        result       = '0;
        lines_new    = '0;

        unique case (command)
            tsp_pkg::PORT_CMD: begin
                slot_next = '0;
                busy_next = 1'b1;
                if (dec.collect) begin
                    bytes_next   = dec.bytes;
                    pending_next = dec.pending;
                    mode_next    = tsp_pkg::MODE_COLLECT;
                end else if (dec.spr_begin) begin
                    mode_next = tsp_pkg::MODE_SPR_BEGIN;
                end else begin
                    mode_next = tsp_pkg::MODE_NOP;
                    busy_next = 1'b0;
                end
            end
            tsp_pkg::PORT_PARAM: begin
                unique case (mode_reg)
                    tsp_pkg::MODE_COLLECT: begin
                        if (bytes_reg != 4'd0) begin
                            // Only the slots that some command reads are kept.
                            unique case (slot_reg)
                                tsp_pkg::SLOT_0:      p0_next  = data_byte;
                                tsp_pkg::SLOT_1:      p1_next  = data_byte;
                                tsp_pkg::SLOT_3:      p3_next  = data_byte;
                                tsp_pkg::SLOT_LINES:  p10_next = data_byte;
                                tsp_pkg::SLOT_LINES8: p11_next = data_byte;
                                default: begin
                                end
                            endcase
                            slot_next  = slot_reg + 4'd1;
                            bytes_next = bytes_reg - 4'd1;
                            if (bytes_reg == 4'd1) begin
                                mode_next = tsp_pkg::MODE_NOP;
                                busy_next = 1'b0;
                                unique case (pending_reg)
                                    tsp_pkg::DO_SYNC: begin
                                        lines_new = {p11_next[6], p10_next};
                                        if (lines_new != lines_reg) begin
                                            lines_next           = lines_new;
                                            result.lines_changed = 1'b1;
                                        end
                                    end
                                    tsp_pkg::DO_DSPON: begin
                                        text_next  = p0_next;
                                        dspon_next = 1'b1;
                                    end
                                    tsp_pkg::DO_DSPDEF: begin
                                        attr_next = {p1_next, p0_next};
                                        lh_next   = {1'b0, p3_next} + 9'd1;
                                    end
                                    tsp_pkg::DO_CURDEF: begin
                                        result.mem_addr = {spr_reg, 8'h00}
                                                        + {8'h00, p0_next[7:3], 3'b001};
                                        result.mem_data = tsp_pkg::CURSOR_MASK;
                                        result.mem_op   = p0_next[1] ? tsp_pkg::MEM_SET
                                                                     : tsp_pkg::MEM_CLEAR;
                                    end
                                    tsp_pkg::DO_SPRON: begin
                                        spr_next   = p0_next;
                                        spron_next = 1'b1;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                    tsp_pkg::MODE_SPR_BEGIN: begin
                        offset_next = {8'h00, data_byte};
                        mode_next   = tsp_pkg::MODE_SPR_STREAM;
                    end
                    tsp_pkg::MODE_SPR_STREAM: begin
                        result.mem_op   = tsp_pkg::MEM_WRITE;
                        result.mem_addr = {spr_reg, 8'h00} + offset_reg;
                        result.mem_data = data_byte;
                        offset_next     = offset_reg + 16'd1;
                    end
                    default: begin
                    end
                endcase
            end
            tsp_pkg::PORT_STATUS: begin
                result.read_data = (busy_reg ? tsp_pkg::BUSY_FLAG : 8'h00)
                                 | (vblank ? tsp_pkg::STATUS_VBLANK : 8'h00);
            end
            default: begin
                result.read_data = tsp_pkg::UNUSED_READ;
            end
        endcase

        // Register fields show their values after this item.
        result.display_on        = dspon_next;
        result.sprites_on        = spron_next;
        result.text_table_base   = {text_next, 8'h00};
        result.sprite_table_base = {spr_next, 8'h00};
        result.attr_offset       = attr_next;
        result.line_height       = lh_next;
        result.screen_lines      = lines_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            mode_reg    <= tsp_pkg::MODE_NOP;
            pending_reg <= tsp_pkg::DO_SYNC;
            bytes_reg   <= '0;
            slot_reg    <= '0;
            offset_reg  <= '0;
            text_reg    <= '0;
            spr_reg     <= '0;
            attr_reg    <= '0;
            lh_reg      <= '0;
            lines_reg   <= '0;
            dspon_reg   <= 1'b0;
            spron_reg   <= 1'b0;
        end else if (step) begin
            busy_reg    <= busy_next;
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            bytes_reg   <= bytes_next;
            slot_reg    <= slot_next;
            offset_reg  <= offset_next;
            text_reg    <= text_next;
            spr_reg     <= spr_next;
            attr_reg    <= attr_next;
            lh_reg      <= lh_next;
            lines_reg   <= lines_next;
            dspon_reg   <= dspon_next;
            spron_reg   <= spron_next;
        end
    end

    // Parameter bytes are always written before a command reads them.
    always_ff @(posedge aclk) begin
        if (step) begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p3_reg  <= p3_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
        end
    end

endmodule

// ===== hw/rtl/text_sprite_command_port.sv =====
// Text and sprite display command port: one bus access in, one result out.
// An input transfer carries the port selector in s_axis_tuser and the byte
// and blanking level in s_axis_tdata. Command bytes start a command, bytes
// on the parameter port are collected, and the last one updates the display
// registers or issues a text memory operation.
// Each input transfer yields exactly one output transfer, through the input
// register and then the output register. While the receiver is ready, the
// block accepts one transfer per cycle: an input register feeds the command
// logic, whose result lands in an output register, and both advance together.
// When the receiver stalls, the output register holds its transfer and one
// more item waits in the input register; then s_axis_tready drops.
// Reset (aresetn low, synchronous) clears busy, the parameter state and the
// display registers, and empties both pipeline registers.
// Depends on tsp_pkg, tsp_core, tsp_cmd_decode and the assertion macros.
`include "text_sprite_command_port_macros.svh"

module text_sprite_command_port (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] data_byte, [8] vblank, [15:9] zero
    input  logic [15:0]  s_axis_tdata,
    // [1:0] command
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] read_data, [23:8] mem_addr, [31:24] mem_data, [32] display_on,
    // [33] sprites_on, [49:34] text_table_base, [65:50] sprite_table_base,
    // [81:66] attr_offset, [90:82] line_height, [99:91] screen_lines,
    // [100] lines_changed, [103:101] zero
    output logic [103:0] m_axis_tdata,
    // [1:0] mem_op
    output logic [1:0]   m_axis_tuser
);

    // Input register.
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_data_reg;
    logic        in_vb_reg;

    // Output register.
    logic              out_valid_reg;
    tsp_pkg::result_t  out_res_reg;
    tsp_pkg::result_t  res_next;

    logic advance;
    logic step;

    // The output register can take a new result when it is empty or its
    // transfer completes in this cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[7:0];
            in_vb_reg   <= s_axis_tdata[8];
        end
    end

    tsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .command   (in_cmd_reg),
        .data_byte (in_data_reg),
        .vblank    (in_vb_reg),
        .result    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.mem_op;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.lines_changed,
                            out_res_reg.screen_lines,
                            out_res_reg.line_height,
                            out_res_reg.attr_offset,
                            out_res_reg.sprite_table_base,
                            out_res_reg.text_table_base,
                            out_res_reg.sprites_on,
                            out_res_reg.display_on,
                            out_res_reg.mem_data,
                            out_res_reg.mem_addr,
                            out_res_reg.read_data};

    // A line count change only comes from a parameter write, never with a
    // memory operation.
    `TSP_ASSERT(a_changed_no_mem, aclk, aresetn, (m_axis_tvalid && out_res_reg.lines_changed) |-> (out_res_reg.mem_op == tsp_pkg::MEM_NONE), "lines_changed together with a memory operation")
    // Cursor set and clear always use the cursor bit mask.
    `TSP_ASSERT(a_cursor_mask, aclk, aresetn, (m_axis_tvalid && (out_res_reg.mem_op == tsp_pkg::MEM_SET || out_res_reg.mem_op == tsp_pkg::MEM_CLEAR)) |-> (out_res_reg.mem_data == tsp_pkg::CURSOR_MASK), "cursor operation with wrong mask")
    // Read data and memory operations come from different ports.
    `TSP_ASSERT(a_read_no_mem, aclk, aresetn, (m_axis_tvalid && out_res_reg.read_data != 8'h00) |-> (out_res_reg.mem_op == tsp_pkg::MEM_NONE), "read data together with a memory operation")
    // With the output register empty the input side never stalls.
    `TSP_ASSERT(a_ready_when_empty, aclk, aresetn, !out_valid_reg |-> s_axis_tready, "input stalled while the output register is empty")
    // Reset empties the output register.
    `TSP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "output valid after reset")

endmodule
